// ===== src/scan_polar_to_cartesian_gate_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scan polar-to-cartesian gate
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SCAN_POLAR_TO_CARTESIAN_GATE_DEFINES_SVH
`define SCAN_POLAR_TO_CARTESIAN_GATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/spc_pkg.sv =====
// ---------------------------------------------------------------------------
// spc_pkg
// Shared constants, types and the arctangent table of the scan gate.
// ---------------------------------------------------------------------------
package spc_pkg;

	// Sizing of the beam counter and the rotator.
	localparam int MAX_BEAMS     = 4096;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int STAGES        = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
	localparam int BEAM_W        = $clog2(MAX_BEAMS);

	// Field widths.
	localparam int RANGE_W    = 16;
	localparam int ANGLE_W    = 16;
	localparam int COORD_W    = 17;
	localparam int BEAM_NUM_W = 12;

	// Datapath widths: coordinates in Q16 millimetres, angle with 2^32 units per turn.
	localparam int XY_W = 35;
	localparam int Z_W  = 34;

	// Inverse CORDIC gain in Q16.
	localparam logic [RANGE_W-1:0] INV_GAIN_Q16 = 16'd39797;

	// Queue between the front and the rotator.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port.
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 2'd3;

	// Output stream packing.
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * COORD_W - BEAM_NUM_W;

	// One gated sample on its way to the rotator.
	typedef struct packed {
		logic [RANGE_W-1:0]    range_mm;
		logic [ANGLE_W-1:0]    angle;
		logic [BEAM_NUM_W-1:0] beam;
	} spc_item_t;

	// round(atan(2^-i) * 2^32 / (2*pi)).
	function automatic logic [Z_W-1:0] atan_entry(input int idx);
		logic [Z_W-1:0] v;
		unique case (idx)
			0:       v = Z_W'(32'h20000000);
			1:       v = Z_W'(32'h12E4051E);
			2:       v = Z_W'(32'h09FB385B);
			3:       v = Z_W'(32'h051111D4);
			4:       v = Z_W'(32'h028B0D43);
			5:       v = Z_W'(32'h0145D7E1);
			6:       v = Z_W'(32'h00A2F61E);
			7:       v = Z_W'(32'h00517C55);
			8:       v = Z_W'(32'h0028BE53);
			9:       v = Z_W'(32'h00145F2F);
			10:      v = Z_W'(32'h000A2F98);
			11:      v = Z_W'(32'h000517CC);
			12:      v = Z_W'(32'h00028BE6);
			13:      v = Z_W'(32'h000145F3);
			14:      v = Z_W'(32'h0000A2FA);
			15:      v = Z_W'(32'h0000517D);
			16:      v = Z_W'(32'h000028BE);
			17:      v = Z_W'(32'h0000145F);
			18:      v = Z_W'(32'h00000A30);
			19:      v = Z_W'(32'h00000518);
			20:      v = Z_W'(32'h0000028C);
			21:      v = Z_W'(32'h00000146);
			22:      v = Z_W'(32'h000000A3);
			23:      v = Z_W'(32'h00000051);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/spc_front.sv =====
// ---------------------------------------------------------------------------
// spc_front
// Holds the configuration registers and the beam state, takes samples and
// pushes the ones inside the range window into the queue.
// ---------------------------------------------------------------------------
module spc_front
	import spc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RANGE_W-1:0]    range_mm,
	input  logic                  scan_start,
	input  logic                  q_full,
	output logic                  push,
	output spc_item_t             item
);

	logic [ANGLE_W-1:0] start_angle_q;
	logic [ANGLE_W-1:0] angle_step_q;
	logic [RANGE_W-1:0] min_range_q;
	logic [RANGE_W-1:0] max_range_q;
	logic [BEAM_W-1:0]  beam_q;
	logic [ANGLE_W-1:0] angle_acc_q;

	logic               accept;
	logic               in_window;
	logic [BEAM_W-1:0]  cur_beam;
	logic [ANGLE_W-1:0] cur_acc;
	logic [BEAM_W-1:0]  next_beam;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			min_range_q   <= '0;
			max_range_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_MIN_RANGE:   min_range_q   <= cfg_data;
				REG_MAX_RANGE:   max_range_q   <= cfg_data;
			endcase
		end
	end

	// A sample is taken whenever the queue has room.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Beam index and accumulated angle of this sample; a scan start restarts both.
	always_comb begin
		cur_beam  = scan_start ? '0 : beam_q;
		cur_acc   = scan_start ? '0 : angle_acc_q;
		next_beam = (cur_beam == BEAM_W'(MAX_BEAMS - 1)) ? '0 : cur_beam + 1'b1;
		in_window = (range_mm >= min_range_q) && (range_mm <= max_range_q);
	end

	// Classify: only samples inside the window go on to the rotator.
	assign push          = accept && in_window;
	assign item.range_mm = range_mm;
	assign item.angle    = start_angle_q + cur_acc;
	assign item.beam     = BEAM_NUM_W'(cur_beam);

	// Every accepted sample advances the beam, gated or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q      <= '0;
			angle_acc_q <= '0;
		end else if (accept) begin
			beam_q      <= next_beam;
			angle_acc_q <= cur_acc + angle_step_q;
		end
	end

endmodule

// ===== src/spc_queue.sv =====
// ---------------------------------------------------------------------------
// spc_queue
// Short first-in first-out queue between the front and the rotator.
// ---------------------------------------------------------------------------
module spc_queue
	import spc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  spc_item_t push_item,
	input  logic      pop,
	output spc_item_t pop_item,
	output logic      empty,
	output logic      full
);

	spc_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_push;
	logic do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/spc_rotator.sv =====
// ---------------------------------------------------------------------------
// spc_rotator
// Pipelined CORDIC in rotation mode: gain prescale and half-turn fold, one
// register stage per iteration, then rounding, saturation and the output
// register of the result stream.
// ---------------------------------------------------------------------------
module spc_rotator
	import spc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  spc_item_t              item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	localparam logic signed [XY_W-16:0] SAT_HI = (XY_W - 15)'(65535);
	localparam logic signed [XY_W-16:0] SAT_LO = -(XY_W - 15)'(65536);

	// Stage 0 is the prescale stage; stage i+1 holds the result of iteration i.
	logic signed [XY_W-1:0]  rx_s [STAGES+1];
	logic signed [XY_W-1:0]  ry_s [STAGES+1];
	logic signed [Z_W-1:0]   rz_s [STAGES+1];
	logic [BEAM_NUM_W-1:0]   rb_s [STAGES+1];
	logic [STAGES:0]         rv_s;

	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;

	logic                    adv;
	logic [2*RANGE_W-1:0]    prod;
	logic signed [ANGLE_W:0] a_ext;
	logic signed [ANGLE_W:0] a_fold;
	logic                    flip;
	logic signed [XY_W-1:0]  x0;
	logic signed [Z_W-1:0]   z0;
	logic [COORD_W-1:0]      px;
	logic [COORD_W-1:0]      py;

	// Round half up to whole millimetres and saturate to the coordinate range.
	function automatic logic [COORD_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
		logic signed [XY_W:0]    t;
		logic signed [XY_W-16:0] r;
		logic [COORD_W-1:0]      o;
		t = {v[XY_W-1], v} + (XY_W + 1)'(32768);
		r = t[XY_W:16];
		if (r > SAT_HI) begin
			o = COORD_W'(SAT_HI);
		end else if (r < SAT_LO) begin
			o = COORD_W'(SAT_LO);
		end else begin
			o = COORD_W'(r);
		end
		return o;
	endfunction

	// The whole pipe moves whenever the output register is free or being taken.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && in_valid;

	// Prescale by the inverse gain and fold angles beyond a quarter turn.
	always_comb begin
		prod  = item.range_mm * INV_GAIN_Q16;
		a_ext = {item.angle[ANGLE_W-1], item.angle};
		flip  = 1'b0;
		if (a_ext > (ANGLE_W + 1)'(16384)) begin
			a_fold = a_ext - (ANGLE_W + 1)'(32768);
			flip   = 1'b1;
		end else if (a_ext < -(ANGLE_W + 1)'(16384)) begin
			a_fold = a_ext + (ANGLE_W + 1)'(32768);
			flip   = 1'b1;
		end else begin
			a_fold = a_ext;
		end
		x0 = flip ? -$signed(XY_W'(prod)) : $signed(XY_W'(prod));
		z0 = {{(Z_W - ANGLE_W - 17){a_fold[ANGLE_W]}}, a_fold, 16'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s[0] <= x0;
			ry_s[0] <= '0;
			rz_s[0] <= z0;
			rb_s[0] <= item.beam;
		end
	end

	// Rotation iterations, one register stage each.
	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;

		assign dx = ry_s[i] >>> i;
		assign dy = rx_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!rz_s[i][Z_W-1]) begin
					rx_s[i+1] <= rx_s[i] - dx;
					ry_s[i+1] <= ry_s[i] + dy;
					rz_s[i+1] <= rz_s[i] - $signed(atan_entry(i));
				end else begin
					rx_s[i+1] <= rx_s[i] + dx;
					ry_s[i+1] <= ry_s[i] - dy;
					rz_s[i+1] <= rz_s[i] + $signed(atan_entry(i));
				end
				rb_s[i+1] <= rb_s[i];
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= '0;
		end else if (adv) begin
			rv_s <= {rv_s[STAGES-1:0], in_valid};
		end
	end

	// Output register of the result stream.
	assign px = round_sat(rx_s[STAGES]);
	assign py = round_sat(ry_s[STAGES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rv_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, rb_s[STAGES], py, px};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/scan_polar_to_cartesian_gate.sv =====
// ---------------------------------------------------------------------------
// scan_polar_to_cartesian_gate
// Lidar range gate and CORDIC polar-to-cartesian converter.
// ---------------------------------------------------------------------------
// Usage:
// Samples enter on the s_axis channel, one beam per transaction: the range in
// millimetres in tdata and a scan start flag in tuser that makes the sample
// beam 0 at the start angle. Each accepted sample advances the beam index and
// angle; samples outside [min_range, max_range] produce no output.
// Points leave on the m_axis channel as rounded, saturated x and y in
// millimetres together with the beam index.
// A sample passes the queue, the prescale stage, one stage per CORDIC
// iteration and the output register. Throughput is one sample per cycle
// while the output is not stalled, set by the fully pipelined rotator.
// When a result waits at the output and m_axis_tready is low the rotator
// pipeline holds; the four-entry queue keeps taking samples until it fills,
// then s_axis_tready drops. Reset clears the configuration to its defaults,
// the beam state, the queue and all pipeline valid bits. Configuration is
// written on cfg_we, one register per cycle; the user must write it only
// while the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module scan_polar_to_cartesian_gate
	import spc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [RANGE_W-1:0]     s_axis_tdata,  // [15:0] range_mm
	input  logic                   s_axis_tuser,  // [0] scan_start
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [16:0] point_x, [33:17] point_y,
	                                              // [45:34] beam_number, [47:46] zero
);

	logic      q_full;
	logic      q_empty;
	logic      q_push;
	logic      q_pop;
	spc_item_t push_item;
	spc_item_t pop_item;

	// Front: configuration, beam state and range gate.
	spc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.range_mm   (s_axis_tdata),
		.scan_start (s_axis_tuser),
		.q_full     (q_full),
		.push       (q_push),
		.item       (push_item)
	);

	// Queue between front and rotator.
	spc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty),
		.full      (q_full)
	);

	// Back: CORDIC pipeline and output register.
	spc_rotator u_rotator (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!q_empty),
		.item      (pop_item),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== src/spc_checker.sv =====
// ---------------------------------------------------------------------------
// spc_checker
// Port-level checks of the scan gate, bound to the top level.
// ---------------------------------------------------------------------------
`include "scan_polar_to_cartesian_gate_defines.svh"

module spc_checker
	import spc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tready,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled output transaction keeps its data.
	`SPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

	// The padding bits above the beam number are always zero.
	`SPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] == '0, "output padding not zero")

	// The input side can only be blocked by a result waiting at the output.
	`SPC_ASSERT_NOW(a_block_on_stall, !s_axis_tready, m_axis_tvalid, "input blocked without pending output")

endmodule

bind scan_polar_to_cartesian_gate spc_checker u_spc_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the scan polar-to-cartesian gate
// Drives range samples into the gate and checks each point that comes out
// against a CORDIC predictor that runs alongside the stimulus. The run opens
// with directed samples on range extremes, quadrant edges, window bounds and
// an empty window. Random scans follow under three idle patterns, and one
// long output stall fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spc_pkg::*;

	// The settle pause leaves room for dropped samples still inside the pipeline.
	localparam int LATENCY          = STAGES + 3;
	localparam int SETTLE_CYCLES    = 2 * LATENCY + 4;
	localparam int RANDOM_PER_PHASE = 140;
	localparam int HOLD_CYCLES      = 400;
	// The longest correct quiet stretch is the output hold plus a settle pause.
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int MAX_PRINTED      = 40;

	// One output transaction, last field in the lowest bits.
	typedef struct packed {
		logic [OUT_PAD_W-1:0]      pad;
		logic [BEAM_NUM_W-1:0]     beam;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	// Predicts the points of the gate and checks the ones that come out.
	class point_scoreboard;
		logic [ANGLE_W-1:0] start_angle;
		logic [ANGLE_W-1:0] angle_step;
		logic [RANGE_W-1:0] min_range;
		logic [RANGE_W-1:0] max_range;
		int unsigned        beam_count;
		logic [ANGLE_W-1:0] beam_angle;
		longint             atan_q32 [TABLE_LEN];
		point_t             expected_points [$];
		int                 mismatches;
		int                 points_checked;
		int                 samples_noted;

		function new();
			real two_pi;
			int  i;
			two_pi = 8.0 * $atan(1.0);
			// Arctangent of 2^-i with 2^32 units per turn.
			for (i = 0; i < TABLE_LEN; i++) begin
				atan_q32[i] = longint'($atan(2.0 ** (-i)) * 4294967296.0 / two_pi);
			end
			start_angle    = '0;
			angle_step     = '0;
			min_range      = '0;
			max_range      = '1;
			beam_count     = 0;
			beam_angle     = '0;
			mismatches     = 0;
			points_checked = 0;
			samples_noted  = 0;
		endfunction

		function void set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_START_ANGLE: start_angle = val;
				REG_ANGLE_STEP:  angle_step  = val;
				REG_MIN_RANGE:   min_range   = val;
				REG_MAX_RANGE:   max_range   = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// Round half up out of Q16, then clamp to the 17-bit signed range.
		function logic [COORD_W-1:0] round_q16(input longint v);
			longint r;
			r = (v + 64'sd32768) >>> 16;
			if (r > 65535)
				r = 65535;
			if (r < -65536)
				r = -65536;
			return r[COORD_W-1:0];
		endfunction

		// CORDIC in rotation mode with the gain folded into the start vector.
		function void rotate(input logic [RANGE_W-1:0] r, input logic [ANGLE_W-1:0] ang,
				output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
			longint a, x, y, z, dx, dy;
			int     i;
			a = longint'(ang);
			if (a >= 32768)
				a -= 65536;
			x = longint'(r) * longint'(INV_GAIN_Q16);
			y = 0;
			// Angles beyond a quarter turn are folded back by half a turn.
			if (a > 16384) begin
				a -= 32768;
				x = -x;
			end else if (a < -16384) begin
				a += 32768;
				x = -x;
			end
			z = a * 65536;
			for (i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q32[i];
				end else begin
					x += dx;
					y -= dy;
					z += atan_q32[i];
				end
			end
			px = round_q16(x);
			py = round_q16(y);
		endfunction

		// An accepted sample advances the beam; a sample in the window adds a point.
		function void note_sample(input logic [RANGE_W-1:0] r, input logic scan_start);
			point_t             p;
			logic [COORD_W-1:0] px, py;
			samples_noted++;
			if (scan_start) begin
				beam_count = 0;
				beam_angle = '0;
			end
			if (r >= min_range && r <= max_range) begin
				rotate(r, start_angle + beam_angle, px, py);
				p.pad  = '0;
				p.beam = beam_count[BEAM_NUM_W-1:0];
				p.x    = px;
				p.y    = py;
				expected_points.insert(expected_points.size(), p);
			end
			beam_angle = beam_angle + angle_step;
			beam_count = (beam_count + 1 >= MAX_BEAMS) ? 0 : beam_count + 1;
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("tb_top: mismatch at %0t: %s", $time, what);
		endtask

		task check_point(input logic [OUT_TDATA_W-1:0] tdata);
			point_t got, want;
			got = tdata;
			points_checked++;
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point x %0d y %0d beam %0d",
					got.x, got.y, got.beam));
				return;
			end
			want = expected_points.pop_front();
			if (got.x !== want.x)
				report_mismatch($sformatf("beam %0d x %0d, want %0d", want.beam, got.x, want.x));
			if (got.y !== want.y)
				report_mismatch($sformatf("beam %0d y %0d, want %0d", want.beam, got.y, want.y));
			if (got.beam !== want.beam)
				report_mismatch($sformatf("beam number %0d, want %0d", got.beam, want.beam));
			if (got.pad !== want.pad)
				report_mismatch($sformatf("beam %0d pad bits %b", want.beam, got.pad));
		endtask
	endclass

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [RANGE_W-1:0]     s_axis_tdata  = '0;  // [15:0] range_mm
	logic                   s_axis_tuser  = 1'b0;  // [0] scan_start
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [16:0] point_x, [33:17] point_y,
	                                       // [45:34] beam_number, [47:46] zero

	point_scoreboard sb;
	int unsigned     send_idle_pct  = 0;
	int unsigned     recv_idle_pct  = 0;
	bit              pressure_armed = 1'b0;
	bit              pressure_done  = 1'b0;
	int              pressure_seen  = 0;
	int              hold_left      = 0;
	int              quiet_cycles   = 0;

	scan_polar_to_cartesian_gate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Output side: check each transaction, then pick the next ready level.
	// Under pressure the receiver holds off for a long stretch after a few points.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_point(m_axis_tdata);
			if (pressure_armed && !pressure_done) begin
				pressure_seen++;
				if (pressure_seen == 20) begin
					hold_left     = HOLD_CYCLES;
					pressure_done = 1'b1;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: watchdog, no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Offer one sample, idling first at the sender's rate, and note it once taken.
	task automatic send_sample(input logic [RANGE_W-1:0] r, input logic scan_start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= r;
		s_axis_tuser  <= scan_start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_sample(r, scan_start);
	endtask

	// Stop offering, wait for every point, then let dropped samples drain.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input logic [15:0] start, input logic [15:0] step,
			input logic [15:0] lo, input logic [15:0] hi);
		quiesce();
		write_reg(REG_START_ANGLE, start);
		write_reg(REG_ANGLE_STEP, step);
		write_reg(REG_MIN_RANGE, lo);
		write_reg(REG_MAX_RANGE, hi);
		cfg_we <= 1'b0;
	endtask

	// Ranges weighted toward the window and its bounds.
	function automatic logic [15:0] pick_range(input logic [15:0] lo, input logic [15:0] hi);
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return 16'($urandom);
		if (sel < 75)
			return (lo <= hi) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
		case ($urandom_range(5))
			0:       return lo - 16'd1;
			1:       return lo;
			2:       return hi;
			3:       return hi + 16'd1;
			4:       return 16'd0;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Mostly well-formed scans of random length; a few lack the start flag
	// and a few carry a stray one.
	task automatic run_scans(input int n_items);
		int   left, scan_len, k;
		logic scan_start;
		left = n_items;
		while (left > 0) begin
			scan_len = $urandom_range(60, 4);
			for (k = 0; k < scan_len && left > 0; k++) begin
				if (k == 0)
					scan_start = ($urandom_range(9) != 0);
				else
					scan_start = ($urandom_range(99) < 2);
				send_sample(pick_range(sb.min_range, sb.max_range), scan_start);
				left--;
			end
		end
	endtask

	initial begin
		int ph, k;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Range extremes at angle zero with the registers as reset left them.
		send_idle_pct = 20;
		recv_idle_pct = 54;
		send_sample(16'd0, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd1, 1'b0);

		// Quadrant edges and the wrap from plus to minus half a turn, one step apart.
		set_config(16'h4000, 16'd1, 16'd0, 16'hFFFF);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'($urandom), 1'b0);
		set_config(16'hBFFF, 16'd1, 16'd0, 16'hFFFF);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'($urandom), 1'b0);
		set_config(16'h7FFF, 16'd1, 16'd0, 16'hFFFF);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hFFFF, 1'b0);

		// Just below, on, and just above each window bound.
		set_config(16'h2000, 16'h1000, 16'd100, 16'd200);
		send_sample(16'd99, 1'b1);
		send_sample(16'd100, 1'b0);
		send_sample(16'd200, 1'b0);
		send_sample(16'd201, 1'b0);

		// Empty window: minimum above maximum passes nothing.
		set_config(16'h0000, 16'd7, 16'd201, 16'd200);
		send_sample(16'd200, 1'b1);
		send_sample(16'd201, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b0);

		// Random scans under three idle patterns and a range of register settings.
		for (ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 54;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (ph)
				0: set_config(16'($urandom), 16'($urandom_range(4095, 1)),
					16'($urandom_range(2000, 0)), 16'($urandom_range(65535, 30000)));
				1: set_config(16'h8000, 16'hFFFF, 16'd0, 16'hFFFF);
				2: begin
					k = $urandom_range(32767, 0);
					set_config(16'($urandom), 16'($urandom), 16'(k),
						16'(k + $urandom_range(512, 0)));
				end
				3: set_config(16'h7FFF, 16'd0, 16'($urandom), 16'hFFFF);
				4: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				default: set_config(16'($urandom), 16'($urandom), 16'd0, 16'hFFFF);
			endcase
			pressure_armed = (ph == 5);
			run_scans(RANDOM_PER_PHASE);
		end

		quiesce();
		$display("tb_top: %0d samples sent, %0d points checked, %0d mismatches",
			sb.samples_noted, sb.points_checked, sb.mismatches);
		$display("tb_top: covered quadrant edges, window bounds, empty window, stalls");
		if (sb.mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
